// File: hw/rtl/rkt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkt_pkg: shared types and constants for the refcounted key table
// Sizes, opcode and status codes, cell data and cell control structs.
// ----------------------------------------------------------------------------
package rkt_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LIVE_W   = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // opcodes
  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_OPEN   = 3'd1;
  localparam logic [2:0] OP_CLOSE  = 3'd2;
  localparam logic [2:0] OP_GET    = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EXISTS    = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] id;
  } cell_data_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
    logic inc;
    logic dec;
  } cell_ctl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } hit_t;

  // lowest set bit of a per-slot vector
  function automatic hit_t first_set(input logic [CAPACITY-1:0] v);
    hit_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/rkt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkt_cell: one table slot
// Holds key, count and id; clears, loads a new entry, steps its count, or takes
// its upper neighbor's entry when it or a lower slot is removed.
// ----------------------------------------------------------------------------
module rkt_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  rkt_pkg::cell_ctl_t          ctl,
  input  rkt_pkg::cell_data_t         nbr,       // entry of the next slot up
  input  logic [rkt_pkg::KEY_W-1:0]   load_key,
  input  logic [rkt_pkg::IDX_W-1:0]   load_id,
  output rkt_pkg::cell_data_t         q
);

  // valid and count reset; key and id are payload and just hold
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
      q.count <= '0;
    end else if (ctl.clear) begin
      q.valid <= 1'b0;
      q.count <= '0;
    end else if (ctl.shift) begin
      q.valid <= nbr.valid;
      q.count <= nbr.count;
      q.key   <= nbr.key;
      q.id    <= nbr.id;
    end else if (ctl.load) begin
      q.valid <= 1'b1;
      q.count <= rkt_pkg::CNT_W'(1);
      q.key   <= load_key;
      q.id    <= load_id;
    end else if (ctl.inc) begin
      q.count <= q.count + rkt_pkg::CNT_W'(1);
    end else if (ctl.dec) begin
      q.count <= q.count - rkt_pkg::CNT_W'(1);
    end
  end

endmodule

// File: hw/rtl/refcounted_key_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_key_table_unit: reference-counted key table
// Fixed table of keyed entries with reference counts and stable ids, kept
// in insertion order in a row of slot cells.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  -------   ---  -----------------  --------------------------------------
//  s         in   s_tvalid/s_tready  tuser: opcode; tdata: key, position,
//                                    close_by_id, entry_id_in
//  m         out  m_tvalid/m_tready  tuser: status; tdata: entry_id,
//                                    removed, live_entries
//  cfg       in   cfg_we             cfg_wdata: reuse_existing
//
//  The accept cycle registers an item; execute then matches all slot cells
//  in parallel and commits the update together with the result register.
//  One item is in flight at a time.
//  A result waiting on m_tready does not block acceptance of the next item;
//  that item holds in execute until the result register frees up.
//  Reset (rst, synchronous) empties the table and frees every id; no
//  clearing pass is needed.
//
module refcounted_key_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // key[31:0], position[35:32], close_by_id[36],
                                 // entry_id_in[40:37], zero fill
  input  logic [2:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // entry_id[3:0], removed[4], live_entries[9:5],
                                 // zero fill
  output logic [2:0]  m_tuser,   // status
  input  logic        cfg_we,
  input  logic        cfg_wdata  // reuse_existing
);

  localparam int CAP = rkt_pkg::CAPACITY;
  localparam int KW  = rkt_pkg::KEY_W;
  localparam int IW  = rkt_pkg::IDX_W;
  localparam int LW  = rkt_pkg::LIVE_W;

  // config
  logic reuse_existing;

  // held item
  logic          busy;
  logic [2:0]    op;
  logic [KW-1:0] op_key;
  logic [IW-1:0] op_pos;
  logic          op_by_id;
  logic [IW-1:0] op_id;

  // table bookkeeping
  logic [LW-1:0]  live;
  logic [LW-1:0]  live_next;
  logic [CAP-1:0] free_map;
  logic [CAP-1:0] free_map_next;

  // result register
  logic [2:0]    res_status;
  logic [IW-1:0] res_id;
  logic          res_removed;
  logic [LW-1:0] res_live;

  // cell row
  rkt_pkg::cell_data_t cell_q   [CAP];
  rkt_pkg::cell_data_t cell_nbr [CAP];
  rkt_pkg::cell_ctl_t  cell_ctl [CAP];
  logic [IW-1:0]       new_id;

  // execute-cycle signals
  logic           exec;
  logic [CAP-1:0] key_hit;
  logic [CAP-1:0] id_hit;
  rkt_pkg::hit_t  key_sel;
  rkt_pkg::hit_t  id_sel;
  rkt_pkg::hit_t  free_sel;
  logic           pos_ok;
  logic           tgt_found;
  logic [IW-1:0]  tgt;
  logic [rkt_pkg::CNT_W-1:0] tgt_cnt;
  logic [IW-1:0]  tgt_id;
  logic           do_remove;
  logic [2:0]     status_c;
  logic [IW-1:0]  eid_c;
  logic           removed_c;

  assign s_tready = !busy;
  assign exec     = busy && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      reuse_existing <= 1'b0;
    end else if (cfg_we) begin
      reuse_existing <= cfg_wdata;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      busy <= 1'b1;
    end else if (exec) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op       <= s_tuser;
      op_key   <= s_tdata[KW-1:0];
      op_pos   <= s_tdata[35:32];
      op_by_id <= s_tdata[36];
      op_id    <= s_tdata[40:37];
    end
  end

  // slot cells: each takes its upper neighbor on a shift, top one takes empty
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    if (g == CAP - 1) begin : g_top
      assign cell_nbr[g] = '0;
    end else begin : g_mid
      assign cell_nbr[g] = cell_q[g+1];
    end

    assign key_hit[g] = cell_q[g].valid && (cell_q[g].key == op_key);
    assign id_hit[g]  = cell_q[g].valid && (cell_q[g].id == op_id);

    rkt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl[g]),
      .nbr      (cell_nbr[g]),
      .load_key (op_key),
      .load_id  (new_id),
      .q        (cell_q[g])
    );
  end

  assign key_sel  = rkt_pkg::first_set(key_hit);
  assign id_sel   = rkt_pkg::first_set(id_hit);
  assign free_sel = rkt_pkg::first_set(free_map);
  assign new_id   = free_sel.idx;
  assign pos_ok   = {1'b0, op_pos} < live;

  // slot addressed by the item
  always_comb begin
    tgt_found = 1'b0;
    tgt       = '0;
    if (op == rkt_pkg::OP_GET) begin
      tgt_found = pos_ok;
      tgt       = op_pos;
    end else if (op == rkt_pkg::OP_CLOSE && op_by_id) begin
      tgt_found = id_sel.found;
      tgt       = id_sel.idx;
    end else begin
      tgt_found = key_sel.found;
      tgt       = key_sel.idx;
    end
  end

  assign tgt_cnt = cell_q[tgt].count;
  assign tgt_id  = cell_q[tgt].id;

  // operation decode and table update
  always_comb begin
    status_c      = rkt_pkg::ST_NOT_FOUND;
    eid_c         = '0;
    removed_c     = 1'b0;
    do_remove     = 1'b0;
    live_next     = live;
    free_map_next = free_map;
    for (int i = 0; i < CAP; i++) begin
      cell_ctl[i] = '0;
    end

    case (op)
      rkt_pkg::OP_CREATE: begin
        if (tgt_found) begin
          if (reuse_existing) begin
            status_c = rkt_pkg::ST_OK;
            eid_c    = tgt_id;
          end else begin
            status_c = rkt_pkg::ST_EXISTS;
          end
        end else if (live >= LW'(CAP) || !free_sel.found) begin
          status_c = rkt_pkg::ST_FULL;
        end else begin
          status_c = rkt_pkg::ST_OK;
          eid_c    = free_sel.idx;
          free_map_next[free_sel.idx] = 1'b0;
          live_next = live + LW'(1);
          for (int i = 0; i < CAP; i++) begin
            cell_ctl[i].load = exec && (LW'(i) == live);
          end
        end
      end
      rkt_pkg::OP_OPEN, rkt_pkg::OP_GET: begin
        if (tgt_found) begin
          eid_c = tgt_id;
          if (tgt_cnt == rkt_pkg::CNT_MAX) begin
            status_c = rkt_pkg::ST_OVERFLOW;
          end else begin
            status_c = rkt_pkg::ST_OK;
            for (int i = 0; i < CAP; i++) begin
              cell_ctl[i].inc = exec && (IW'(i) == tgt);
            end
          end
        end
      end
      rkt_pkg::OP_CLOSE: begin
        if (tgt_found) begin
          status_c = rkt_pkg::ST_OK;
          eid_c    = tgt_id;
          if (tgt_cnt <= rkt_pkg::CNT_W'(1)) begin
            // last reference: free the id, close the gap
            do_remove = 1'b1;
            removed_c = 1'b1;
            free_map_next[tgt_id] = 1'b1;
            live_next = live - LW'(1);
          end
          for (int i = 0; i < CAP; i++) begin
            cell_ctl[i].shift = exec && do_remove && (IW'(i) >= tgt);
            cell_ctl[i].dec   = exec && !do_remove && (IW'(i) == tgt);
          end
        end
      end
      rkt_pkg::OP_CLEAR: begin
        status_c      = rkt_pkg::ST_OK;
        live_next     = '0;
        free_map_next = '1;
        for (int i = 0; i < CAP; i++) begin
          cell_ctl[i].clear = exec;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live     <= '0;
      free_map <= '1;
    end else if (exec) begin
      live     <= live_next;
      free_map <= free_map_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res_status  <= status_c;
      res_id      <= eid_c;
      res_removed <= removed_c;
      res_live    <= live_next;
    end
  end

  assign m_tuser = res_status;
  assign m_tdata = {6'd0, res_live, res_removed, res_id};

endmodule

// File: hw/rtl/rkt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkt_checker: port-level checks for the refcounted key table
// Watches the stream ports; bound to the top level.
// ----------------------------------------------------------------------------
module rkt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // one item in flight: no transfer in the cycle after an input transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in flight");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[9:5] <= 5'(rkt_pkg::CAPACITY))
    else $error("live entry count beyond capacity");

  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tuser == rkt_pkg::ST_OK)
    else $error("removed flag on a failed operation");

  a_fail_id_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == rkt_pkg::ST_EXISTS || m_tuser == rkt_pkg::ST_NOT_FOUND ||
                 m_tuser == rkt_pkg::ST_FULL) |-> m_tdata[3:0] == 4'd0)
    else $error("failed operation reports a nonzero entry id");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

endmodule

bind refcounted_key_table_unit rkt_checker u_rkt_checker (.*);
